// ----- design/gbsp_pkg.sv -----
// Package with shared types and constants for the grid shortest-path block.
`default_nettype none
package gbsp_pkg;
    localparam int CELL_W = 7;
    localparam int COLS = 4;
    localparam logic CFG_TOTAL_CELLS = 1'b0;
    localparam logic CFG_PIECE_IS_KNIGHT = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_POP    = 10'b0000000010,
        ST_CUR    = 10'b0000000100,
        ST_NBR    = 10'b0000001000,
        ST_CHECK  = 10'b0000010000,
        ST_WALK   = 10'b0000100000,
        ST_WALKRD = 10'b0001000000,
        ST_EMIT   = 10'b0010000000,
        ST_EMITRD = 10'b0100000000,
        ST_FAIL   = 10'b1000000000
    } t_state;

    // Signed row and column steps for move i of the chosen piece.
    function automatic logic signed [2:0] move_dr(input logic knight, input logic [2:0] i);
        logic signed [2:0] r;
        r = 3'sd0;
        if (knight) begin
            case (i)
                3'd0, 3'd1: r = -3'sd2;
                3'd2, 3'd3: r = -3'sd1;
                3'd4, 3'd5: r = 3'sd1;
                default:    r = 3'sd2;
            endcase
        end else begin
            case (i[1:0])
                2'd0:    r = -3'sd1;
                2'd3:    r = 3'sd1;
                default: r = 3'sd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic signed [2:0] move_dc(input logic knight, input logic [2:0] i);
        logic signed [2:0] c;
        c = 3'sd0;
        if (knight) begin
            case (i)
                3'd0, 3'd6: c = -3'sd1;
                3'd1, 3'd7: c = 3'sd1;
                3'd2, 3'd4: c = -3'sd2;
                default:    c = 3'sd2;
            endcase
        end else begin
            c = i[0] ? 3'sd1 : -3'sd1;
        end
        return c;
    endfunction
endpackage
`default_nettype wire

// ----- design/gbsp_mem.sv -----
// Synchronous single-port-write, registered-read memory for queue and parent storage.
`default_nettype none
module gbsp_mem
    import gbsp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [CELL_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [CELL_W-1:0]        o_rdata
);
    logic [CELL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/grid_bfs_shortest_path.sv -----
// Top level: breadth-first knight or wounded-king shortest path on a four-column board.
// Equal cells answer straight from idle and off-board cells through the fail state; a search
// loads the queue, dequeues each cell and checks each of its moves in turn, then walks the
// parent chain back from the end cell and emits the path one word at a time.
// One query at a time and no output stall; busy drops as the last word appears.
// Synchronous active-low reset returns to idle with total_cells 64, knight moves.
`default_nettype none
module grid_bfs_shortest_path
    import gbsp_pkg::*;
#(
    parameter int MAX_CELLS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CELL_W-1:0] i_start_cell,
    input  wire logic [CELL_W-1:0] i_end_cell,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [CELL_W-1:0] i_cfg_data,
    output logic                   o_valid,
    output logic      [CELL_W-1:0] o_path_cell,
    output logic                   o_found,
    output logic                   o_last
);
    localparam int AW = $clog2(MAX_CELLS);

    t_state r_state;
    logic [CELL_W-1:0] r_total, r_start, r_end, r_cur, r_nx, r_v;
    logic r_knight;
    logic [MAX_CELLS-1:0] r_vis;
    logic [AW:0] r_head, r_tail, r_len;
    logic [2:0] r_mv;
    logic [CELL_W-1:0] q_rdata, p_rdata;
    logic q_we, p_we;
    logic [AW-1:0] q_waddr, q_raddr, p_waddr, p_raddr;
    logic [CELL_W-1:0] q_wdata, p_wdata;
    logic [CELL_W-1:0] size;
    logic [CELL_W-1:0] nbr;
    logic [CELL_W-1:0] cur_in;
    logic last_mv;
    logic cells_bad;
    logic [AW:0] max_q;

    // The queue holds the BFS frontier; the path stack reuses it after the search.
    gbsp_mem #(.DEPTH(MAX_CELLS)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata));
    gbsp_mem #(.DEPTH(MAX_CELLS)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata));

    assign max_q = (AW+1)'(MAX_CELLS);
    assign size = (r_total > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS) : r_total;
    assign last_mv = r_knight ? (r_mv == 3'd7) : (r_mv == 3'd3);
    assign busy = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cells_bad = (i_start_cell < 1 || i_start_cell > size ||
                        i_end_cell < 1 || i_end_cell > size);
    // The first move of a cell uses the word just read from the queue.
    assign cur_in = (r_state == ST_NBR && r_mv == 3'd0) ? q_rdata : r_cur;

    always_comb begin
        logic signed [CELL_W+1:0] row, col, num;
        row = $signed({2'b00, (cur_in - 7'd1) >> 2}) + move_dr(r_knight, r_mv);
        col = $signed({7'b0, cur_in[1:0] - 2'd1}) + move_dc(r_knight, r_mv);
        num = (row <<< 2) + col + 9'sd1;
        if (row < 0 || col < 0 || col >= COLS || num < 1 || num > $signed({2'b0, size}))
            nbr = '0;
        else
            nbr = num[CELL_W-1:0];
    end

    always_comb begin
        q_we = 1'b0; q_waddr = r_tail[AW-1:0]; q_wdata = r_nx;
        q_raddr = r_head[AW-1:0];
        p_we = 1'b0; p_waddr = AW'(r_nx - 7'd1); p_wdata = r_cur;
        p_raddr = AW'(r_v - 7'd1);
        case (r_state)
            ST_POP: begin
                q_we = 1'b1; q_waddr = '0;
            end
            ST_CHECK: begin
                if (r_nx != 0 && !r_vis[AW'(r_nx - 7'd1)]) begin
                    p_we = 1'b1;
                    q_we = (r_tail < max_q);
                end
            end
            ST_WALK: begin
                q_we = 1'b1; q_waddr = r_len[AW-1:0]; q_wdata = r_v;
            end
            ST_EMIT, ST_EMITRD: q_raddr = AW'(r_len - 1'b1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= 7'd64;
            r_knight <= 1'b1;
            r_head <= '0;
            r_tail <= '0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == CFG_TOTAL_CELLS) r_total <= i_cfg_data;
                        else r_knight <= i_cfg_data[0];
                    end
                    if (start) begin
                        r_start <= i_start_cell;
                        r_end <= i_end_cell;
                        if (cells_bad) begin
                            r_state <= ST_FAIL;
                        end else if (i_start_cell == i_end_cell) begin
                            o_path_cell <= i_start_cell;
                            o_found <= 1'b1; o_last <= 1'b1;
                        end else begin
                            r_vis <= {{(MAX_CELLS-1){1'b0}}, 1'b1} <<
                                     AW'(i_start_cell - 7'd1);
                            r_head <= '0; r_tail <= (AW+1)'(1);
                            r_nx <= i_start_cell;
                            r_state <= ST_POP;
                        end
                    end
                end
                ST_POP: begin
                    // Writes the start cell into the queue head before the first dequeue.
                    r_state <= ST_CUR;
                end
                ST_CUR: begin
                    if (r_head < r_tail && r_head < max_q) begin
                        r_head <= r_head + 1'b1;
                        r_mv <= 3'd0;
                        r_state <= ST_NBR;
                    end else begin
                        r_state <= ST_FAIL;
                    end
                end
                ST_NBR: begin
                    if (r_mv == 3'd0) r_cur <= q_rdata;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_nx != 0 && !r_vis[AW'(r_nx - 7'd1)]) begin
                        r_vis[AW'(r_nx - 7'd1)] <= 1'b1;
                        if (r_tail < max_q) r_tail <= r_tail + 1'b1;
                    end
                    if (r_nx != 0 && !r_vis[AW'(r_nx - 7'd1)] && r_nx == r_end) begin
                        r_v <= r_end; r_len <= '0;
                        r_state <= ST_WALK;
                    end else if (last_mv) begin
                        r_state <= ST_CUR;
                    end else begin
                        r_mv <= r_mv + 3'd1;
                        r_state <= ST_NBR;
                    end
                end
                ST_WALK: begin
                    r_len <= r_len + 1'b1;
                    if (r_v == r_start || r_len + 1'b1 >= max_q) r_state <= ST_EMIT;
                    else r_state <= ST_WALKRD;
                end
                ST_WALKRD: begin
                    r_v <= p_rdata;
                    if (p_rdata < 1 || p_rdata > size) r_state <= ST_EMIT;
                    else r_state <= ST_WALK;
                end
                ST_EMIT: r_state <= ST_EMITRD;
                ST_EMITRD: begin
                    o_path_cell <= q_rdata; o_found <= 1'b1;
                    o_last <= (r_len == (AW+1)'(1));
                    r_len <= r_len - 1'b1;
                    r_state <= (r_len == (AW+1)'(1)) ? ST_IDLE : ST_EMIT;
                end
                ST_FAIL: begin
                    o_path_cell <= '0; o_found <= 1'b0; o_last <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
            o_valid <= (r_state == ST_EMITRD) || (r_state == ST_FAIL) ||
                       (r_state == ST_IDLE && start && !cells_bad &&
                        i_start_cell == i_end_cell);
            // Neighbour cell is registered in the cycle before its check.
            if (r_state == ST_NBR) r_nx <= nbr;
        end
    end

`ifndef NO_ASSERTIONS
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_head <= r_tail) else $error("queue head passed tail");
    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> o_last) else $error("failure word not last");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy) else $error("busy after last word");
`endif
endmodule
`default_nettype wire
